[src/fatl_pkg.sv]
// Shared types, widths and constants of the FAT entry and cluster locator.
// Used by fatl_sdiv, fatl_pdiv and fat_entry_and_cluster_locator; no dependencies.
package fatl_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned BPS_W     = 13;
  localparam int unsigned SPC_W     = 8;
  localparam int unsigned RSV_W     = 16;
  localparam int unsigned NFAT_W    = 8;
  localparam int unsigned REC_W     = 16;
  localparam int unsigned SIC_W     = 7;
  localparam int unsigned OFS_W     = 12;
  localparam int unsigned CFG_IDX_W = 3;

  // Quotient bits resolved per stage of the per-word divider.
  localparam int unsigned DEF_DIV_BITS_PER_STAGE = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_SECTOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_CLUSTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_SECTORS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_OF_FATS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_ENTRY_COUNT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FAT_SIZE_SECTORS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SECTORS       = 3'd6;

  // Register values after reset (a 1.44 MB floppy layout).
  localparam logic [BPS_W-1:0]  RST_BYTES_PER_SECTOR    = 13'd512;
  localparam logic [SPC_W-1:0]  RST_SECTORS_PER_CLUSTER = 8'd1;
  localparam logic [RSV_W-1:0]  RST_RESERVED_SECTORS    = 16'd1;
  localparam logic [NFAT_W-1:0] RST_NUMBER_OF_FATS      = 8'd2;
  localparam logic [REC_W-1:0]  RST_ROOT_ENTRY_COUNT    = 16'd224;
  localparam logic [WORD_W-1:0] RST_FAT_SIZE_SECTORS    = 32'd9;
  localparam logic [WORD_W-1:0] RST_TOTAL_SECTORS       = 32'd2880;

  // Geometry constants.
  localparam logic [WORD_W-1:0] FAT16_MIN_CLUSTERS_MINUS_ONE = 32'd4084;
  localparam int unsigned       DIR_ENTRY_SHIFT              = 5;   // 32-byte entries
  localparam logic [WORD_W-1:0] FAT12_ENTRY_BITS             = 32'd12;
  localparam logic [WORD_W-1:0] FIRST_DATA_CLUSTER           = 32'd2;
  localparam logic [WORD_W-1:0] FAT12_RSV_START              = 32'h0000_0FF0;
  localparam logic [WORD_W-1:0] FAT16_RSV_START              = 32'h0000_FFF0;
  localparam logic [WORD_W-1:0] FAT32_RSV_START              = 32'h0FFF_FFF0;

  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2
  } fat_kind_t;

  // Sequencer that derives the geometry values after reset or a register write.
  typedef enum logic [2:0] {
    SEQ_ROOT,
    SEQ_ROOT_WAIT,
    SEQ_FIRST,
    SEQ_COUNT,
    SEQ_COUNT_WAIT,
    SEQ_READY
  } seq_state_t;

  // Fields that ride along the divider pipeline beside the division itself.
  typedef struct packed {
    fat_kind_t         kind;
    logic              odd_nibble;
    logic              end_of_chain;
    logic [WORD_W-1:0] data_sector;
  } side_t;

endpackage

[src/fat_entry_and_cluster_locator.sv]
// Top level of the FAT entry and cluster locator: configuration registers,
// geometry sequencer and item pipeline. Depends on fatl_pkg, fatl_sdiv, fatl_pdiv.

// For each cluster number word taken on start, the block returns the FAT variant,
// the sector and byte offset of the cluster's entry in the first FAT, the odd
// nibble flag of FAT12, the end-of-chain flag and the absolute sector of the
// requested sector of the cluster's data. A word is taken at a clock edge with
// start high and busy low; one result word appears on the out_ ports for a single
// cycle with out_strobe high, once it has passed the input register, the entry
// offset stage, the divider stages and the output register. The receiver cannot
// stall, so the pipeline never holds and a new word may be taken in every cycle
// while busy is low. The values derived from the boot-sector geometry (first
// data sector, cluster count and FAT variant) are worked out by a sequencer that
// shares one serial divider, a bit per cycle; it runs after reset and after every
// configuration write, and busy stays high meanwhile. Writes are always taken
// (cfg_ready is tied high) and a write to an unknown index leaves the registers
// as they were but still restarts the sequencer. Registers may be written only
// while no result is outstanding.
module fat_entry_and_cluster_locator #(
  parameter int unsigned DIV_BITS_PER_STAGE = fatl_pkg::DEF_DIV_BITS_PER_STAGE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input word.
  input  logic                           start,
  output logic                           busy,
  input  logic [fatl_pkg::WORD_W-1:0]    in_cluster,
  input  logic [fatl_pkg::SIC_W-1:0]     in_sector_in_cluster,
  // Result word.
  output logic                           out_strobe,
  output logic [1:0]                     out_fat_kind,
  output logic [fatl_pkg::WORD_W-1:0]    out_fat_sector,
  output logic [fatl_pkg::OFS_W-1:0]     out_fat_byte_offset,
  output logic                           out_odd_nibble,
  output logic                           out_end_of_chain,
  output logic [fatl_pkg::WORD_W-1:0]    out_data_sector,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fatl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fatl_pkg::WORD_W-1:0]    cfg_data
);

  localparam int unsigned W       = fatl_pkg::WORD_W;
  localparam int unsigned STAGES  = W / DIV_BITS_PER_STAGE;
  localparam int unsigned LATENCY = STAGES + 3;

  // ---------------------------------------------------------------------------
  // Configuration registers. The write port never pushes back.
  // ---------------------------------------------------------------------------
  logic                         cfg_wr;
  logic [fatl_pkg::BPS_W-1:0]   bps_r;
  logic [fatl_pkg::SPC_W-1:0]   spc_r;
  logic [fatl_pkg::RSV_W-1:0]   rsv_r;
  logic [fatl_pkg::NFAT_W-1:0]  nfat_r;
  logic [fatl_pkg::REC_W-1:0]   rec_r;
  logic [W-1:0]                 fsz_r;
  logic [W-1:0]                 tot_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r  <= fatl_pkg::RST_BYTES_PER_SECTOR;
      spc_r  <= fatl_pkg::RST_SECTORS_PER_CLUSTER;
      rsv_r  <= fatl_pkg::RST_RESERVED_SECTORS;
      nfat_r <= fatl_pkg::RST_NUMBER_OF_FATS;
      rec_r  <= fatl_pkg::RST_ROOT_ENTRY_COUNT;
      fsz_r  <= fatl_pkg::RST_FAT_SIZE_SECTORS;
      tot_r  <= fatl_pkg::RST_TOTAL_SECTORS;
    end else if (cfg_wr) begin
      case (cfg_index)
        fatl_pkg::CFG_BYTES_PER_SECTOR:    bps_r  <= cfg_data[fatl_pkg::BPS_W-1:0];
        fatl_pkg::CFG_SECTORS_PER_CLUSTER: spc_r  <= cfg_data[fatl_pkg::SPC_W-1:0];
        fatl_pkg::CFG_RESERVED_SECTORS:    rsv_r  <= cfg_data[fatl_pkg::RSV_W-1:0];
        fatl_pkg::CFG_NUMBER_OF_FATS:      nfat_r <= cfg_data[fatl_pkg::NFAT_W-1:0];
        fatl_pkg::CFG_ROOT_ENTRY_COUNT:    rec_r  <= cfg_data[fatl_pkg::REC_W-1:0];
        fatl_pkg::CFG_FAT_SIZE_SECTORS:    fsz_r  <= cfg_data;
        fatl_pkg::CFG_TOTAL_SECTORS:       tot_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Geometry sequencer. It first divides the root directory size by the sector
  // size, then forms the first data sector, then divides the data area by the
  // cluster size to get the cluster count; it and the root entry count pick the FAT variant.
  // ---------------------------------------------------------------------------
  fatl_pkg::seq_state_t state_r, state_nxt;
  logic                 div_start;
  logic                 div_done;
  logic                 sel_count;
  logic                 load_first;
  logic                 load_kind;
  logic [W-1:0]         div_dividend;
  logic [W-1:0]         div_divisor;
  logic [W-1:0]         div_quotient;
  logic [W-1:0]         root_bytes;
  logic [39:0]          nf_fs;
  logic [W-1:0]         first_r;
  fatl_pkg::fat_kind_t  kind_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fatl_pkg::SEQ_ROOT:       state_nxt = fatl_pkg::SEQ_ROOT_WAIT;
      fatl_pkg::SEQ_ROOT_WAIT:  if (div_done) state_nxt = fatl_pkg::SEQ_FIRST;
      fatl_pkg::SEQ_FIRST:      state_nxt = fatl_pkg::SEQ_COUNT;
      fatl_pkg::SEQ_COUNT:      state_nxt = fatl_pkg::SEQ_COUNT_WAIT;
      fatl_pkg::SEQ_COUNT_WAIT: if (div_done) state_nxt = fatl_pkg::SEQ_READY;
      fatl_pkg::SEQ_READY:      state_nxt = fatl_pkg::SEQ_READY;
      default:                  state_nxt = fatl_pkg::SEQ_ROOT;
    endcase
    // Any write may change the geometry, so the derivation starts over.
    if (cfg_wr) begin
      state_nxt = fatl_pkg::SEQ_ROOT;
    end
  end

  always_comb begin
    div_start  = 1'b0;
    sel_count  = 1'b0;
    load_first = 1'b0;
    load_kind  = 1'b0;
    busy       = 1'b1;
    case (state_r)
      fatl_pkg::SEQ_ROOT:       div_start = 1'b1;
      fatl_pkg::SEQ_ROOT_WAIT:  ;
      fatl_pkg::SEQ_FIRST:      load_first = 1'b1;
      fatl_pkg::SEQ_COUNT: begin
        div_start = 1'b1;
        sel_count = 1'b1;
      end
      fatl_pkg::SEQ_COUNT_WAIT: begin
        sel_count = 1'b1;
        load_kind = div_done;
      end
      fatl_pkg::SEQ_READY:      busy = 1'b0;
      default:                  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fatl_pkg::SEQ_ROOT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Root directory size in bytes plus the rounding term; wraps like the 32-bit
  // sum it stands for when the sector size is zero.
  assign root_bytes = (W'(rec_r) << fatl_pkg::DIR_ENTRY_SHIFT) + (W'(bps_r) - W'(1));

  assign div_dividend = sel_count ? (tot_r - first_r) : root_bytes;
  assign div_divisor  = sel_count ? W'(spc_r) : W'(bps_r);

  fatl_sdiv u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign nf_fs = 40'(nfat_r) * 40'(fsz_r);

  // The root directory quotient is still held by the divider in SEQ_FIRST.
  always_ff @(posedge clk) begin
    if (load_first) begin
      first_r <= W'(rsv_r) + nf_fs[W-1:0] + div_quotient;
    end
    if (load_kind) begin
      if (rec_r == '0) begin
        kind_r <= fatl_pkg::KIND_FAT32;
      end else if (div_quotient > fatl_pkg::FAT16_MIN_CLUSTERS_MINUS_ONE) begin
        kind_r <= fatl_pkg::KIND_FAT16;
      end else begin
        kind_r <= fatl_pkg::KIND_FAT12;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Item pipeline: input register, entry offset stage, divider stages, output
  // register. Valid bits travel with each word.
  // ---------------------------------------------------------------------------
  logic                       accept;
  logic                       v0_r;
  logic [W-1:0]               cluster0_r;
  logic [fatl_pkg::SIC_W-1:0] sic0_r;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    cluster0_r <= in_cluster;
    sic0_r     <= in_sector_in_cluster;
  end

  // Entry byte position and flags by variant. A FAT12 entry is a byte and a
  // half, so odd clusters begin in the upper nibble.
  logic [W-1:0]               fat12_bits;
  logic [W-1:0]               entry_nxt;
  logic                       odd_nxt;
  logic                       eoc_nxt;
  logic [39:0]                data_prod;
  logic                       v1_r;
  logic [W-1:0]               entry1_r;
  logic                       odd1_r;
  logic                       eoc1_r;
  fatl_pkg::fat_kind_t        kind1_r;
  logic [W-1:0]               prod1_r;
  logic [fatl_pkg::SIC_W-1:0] sic1_r;

  assign fat12_bits = cluster0_r * fatl_pkg::FAT12_ENTRY_BITS;
  assign data_prod  = 40'(spc_r) * 40'(cluster0_r - fatl_pkg::FIRST_DATA_CLUSTER);

  always_comb begin
    entry_nxt = W'(fat12_bits[W-1:3]);
    odd_nxt   = fat12_bits[2:0] != 3'd0;
    eoc_nxt   = cluster0_r >= fatl_pkg::FAT12_RSV_START;
    case (kind_r)
      fatl_pkg::KIND_FAT32: begin
        entry_nxt = {cluster0_r[W-3:0], 2'b00};
        odd_nxt   = 1'b0;
        eoc_nxt   = cluster0_r >= fatl_pkg::FAT32_RSV_START;
      end
      fatl_pkg::KIND_FAT16: begin
        entry_nxt = {cluster0_r[W-2:0], 1'b0};
        odd_nxt   = 1'b0;
        eoc_nxt   = cluster0_r >= fatl_pkg::FAT16_RSV_START;
      end
      fatl_pkg::KIND_FAT12: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    entry1_r <= entry_nxt;
    odd1_r   <= odd_nxt;
    eoc1_r   <= eoc_nxt;
    kind1_r  <= kind_r;
    prod1_r  <= data_prod[W-1:0];
    sic1_r   <= sic0_r;
  end

  // The data sector sum is formed beside the first divider stage.
  fatl_pkg::side_t            side_in;
  fatl_pkg::side_t            side_out;
  logic                       dv_valid;
  logic [W-1:0]               dv_quotient;
  logic [fatl_pkg::BPS_W-1:0] dv_remainder;

  always_comb begin
    side_in.kind         = kind1_r;
    side_in.odd_nibble   = odd1_r;
    side_in.end_of_chain = eoc1_r;
    side_in.data_sector  = prod1_r + first_r + W'(sic1_r);
  end

  fatl_pdiv #(
    .BITS_PER_STAGE (DIV_BITS_PER_STAGE)
  ) u_pdiv (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (v1_r),
    .in_dividend   (entry1_r),
    .in_side       (side_in),
    .divisor       (bps_r),
    .out_valid     (dv_valid),
    .out_quotient  (dv_quotient),
    .out_remainder (dv_remainder),
    .out_side      (side_out)
  );

  // Output register: add the reserved area to the FAT sector.
  logic                       strobe_r;
  logic [1:0]                 kind_out_r;
  logic [W-1:0]               fat_sector_r;
  logic [fatl_pkg::OFS_W-1:0] offset_r;
  logic                       odd_out_r;
  logic                       eoc_out_r;
  logic [W-1:0]               data_sector_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    kind_out_r    <= side_out.kind;
    fat_sector_r  <= dv_quotient + W'(rsv_r);
    offset_r      <= dv_remainder[fatl_pkg::OFS_W-1:0];
    odd_out_r     <= side_out.odd_nibble;
    eoc_out_r     <= side_out.end_of_chain;
    data_sector_r <= side_out.data_sector;
  end

  assign out_strobe          = strobe_r;
  assign out_fat_kind        = kind_out_r;
  assign out_fat_sector      = fat_sector_r;
  assign out_fat_byte_offset = offset_r;
  assign out_odd_nibble      = odd_out_r;
  assign out_end_of_chain    = eoc_out_r;
  assign out_data_sector     = data_sector_r;

`ifndef SYNTHESIS
  // Every word taken comes out with out_strobe high after passing the whole pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##(LATENCY) out_strobe)
    else $error("result word missing at the pipeline latency");

  // A register write always restarts the geometry derivation.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy)
    else $error("busy low right after a register write");

  // The nibble flag belongs to FAT12 entries only.
  a_odd_fat12: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_fat_kind != fatl_pkg::KIND_FAT12) |-> !out_odd_nibble)
    else $error("odd nibble flagged outside FAT12");

  // The derived variant must not move while words are being taken.
  a_kind_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && $past(!busy) |-> $stable(kind_r))
    else $error("FAT variant changed while ready");
`endif

endmodule

[src/fatl_sdiv.sv]
// Serial restoring divider, one quotient bit per cycle, 32-bit operands.
// Depends on fatl_pkg for the word width.
module fatl_sdiv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fatl_pkg::WORD_W-1:0] dividend,
  input  logic [fatl_pkg::WORD_W-1:0] divisor,
  output logic                       done,
  output logic [fatl_pkg::WORD_W-1:0] quotient
);

  localparam int unsigned W     = fatl_pkg::WORD_W;
  localparam int unsigned CNT_W = $clog2(W);

  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     num_r, num_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [W:0]       shifted;

  // A zero divisor always subtracts, giving an all-ones quotient.
  always_comb begin
    shifted = {rem_r, num_r[W-1]};
    num_nxt = {num_r[W-2:0], 1'b0};
    rem_nxt = shifted[W-1:0];
    if (shifted >= {1'b0, divisor}) begin
      rem_nxt    = W'(shifted - {1'b0, divisor});
      num_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

[src/fatl_pdiv.sv]
// Pipelined restoring divider of a 32-bit word by the 13-bit sector size,
// with a side payload carried in step. Depends on fatl_pkg.
module fatl_pdiv #(
  parameter int unsigned BITS_PER_STAGE = fatl_pkg::DEF_DIV_BITS_PER_STAGE
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [fatl_pkg::WORD_W-1:0] in_dividend,
  input  fatl_pkg::side_t             in_side,
  input  logic [fatl_pkg::BPS_W-1:0]  divisor,
  output logic                        out_valid,
  output logic [fatl_pkg::WORD_W-1:0] out_quotient,
  output logic [fatl_pkg::BPS_W-1:0]  out_remainder,
  output fatl_pkg::side_t             out_side
);

  localparam int unsigned W      = fatl_pkg::WORD_W;
  localparam int unsigned REM_W  = fatl_pkg::BPS_W;
  localparam int unsigned STAGES = W / BITS_PER_STAGE;

  logic [STAGES-1:0] vld_r;
  logic [REM_W-1:0]  rem_r  [STAGES];
  logic [REM_W-1:0]  rem_nxt[STAGES];
  logic [W-1:0]      num_r  [STAGES];
  logic [W-1:0]      num_nxt[STAGES];
  fatl_pkg::side_t   side_r [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [W-1:0]     num_in;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = in_dividend;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign num_in = num_r[g-1];
    end

    // Dividend bits leave at the top of num while quotient bits enter at the bottom.
    always_comb begin : p_step
      logic [REM_W-1:0] r;
      logic [W-1:0]     n;
      logic [REM_W:0]   sh;
      r = rem_in;
      n = num_in;
      for (int i = 0; i < BITS_PER_STAGE; i++) begin
        sh = {r, n[W-1]};
        n  = {n[W-2:0], 1'b0};
        if (sh >= {1'b0, divisor}) begin
          sh   = sh - {1'b0, divisor};
          n[0] = 1'b1;
        end
        r = sh[REM_W-1:0];
      end
      rem_nxt[g] = r;
      num_nxt[g] = n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= in_side;
    for (int s = 1; s < STAGES; s++) begin
      side_r[s] <= side_r[s-1];
    end
    for (int s = 0; s < STAGES; s++) begin
      rem_r[s] <= rem_nxt[s];
      num_r[s] <= num_nxt[s];
    end
  end

  assign out_valid     = vld_r[STAGES-1];
  assign out_quotient  = num_r[STAGES-1];
  assign out_remainder = rem_r[STAGES-1];
  assign out_side      = side_r[STAGES-1];

endmodule
